[rtl/core/tiracl_pkg.sv]
package tiracl_pkg;

    localparam int RULE_SLOTS_DEF = 16;
    localparam int SLOT_W         = 4;
    localparam int ADDR_W         = 32;
    localparam int SEC_W          = 17;
    localparam int DAYS_W         = 7;
    localparam int LEVEL_W        = 10;
    localparam int WDAY_W         = 3;
    localparam int OCTETS         = 4;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_CHECK = 1'b1
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [SLOT_W-1:0]   slot;
        logic [ADDR_W-1:0]   range_low;
        logic [ADDR_W-1:0]   range_high;
        logic [SEC_W-1:0]    window_start;
        logic [SEC_W-1:0]    window_end;
        logic [DAYS_W-1:0]   day_set;
        logic [LEVEL_W-1:0]  level_limit;
        logic [ADDR_W-1:0]   address;
        logic [LEVEL_W-1:0]  user_level;
        logic [SEC_W-1:0]    second_of_day;
        logic [WDAY_W-1:0]   weekday;
    } request_t;

    typedef struct packed {
        logic                denied;
        logic [SLOT_W-1:0]   hit_slot;
    } result_t;

    typedef struct packed {
        logic                en;
        logic [SLOT_W-1:0]   slot;
        logic [ADDR_W-1:0]   low_bound;
        logic [ADDR_W-1:0]   high_bound;
        logic [SEC_W-1:0]    start_sec;
        logic [SEC_W-1:0]    end_sec;
        logic [DAYS_W-1:0]   days;
        logic [LEVEL_W-1:0]  max_level;
    } rule_wr_t;

    typedef struct packed {
        logic                valid;
        logic [ADDR_W-1:0]   address;
        logic [LEVEL_W-1:0]  user_level;
        logic [SEC_W-1:0]    second_of_day;
        logic [WDAY_W-1:0]   weekday;
        logic                found;
        logic [SLOT_W-1:0]   hit;
    } query_t;

endpackage

[rtl/core/timed_ip_range_acl_match_unit.sv]
// Access rule matcher: a table of RULE_SLOTS rules, one per cell in a chain.
// Command channel: present request and raise start; the item is taken at a
// rising edge with start high and busy low. busy stays high until the result
// strobe has been shown.
// Write item (op = write): fills one slot at the accepting edge; done pulses
// in the next cycle with denied = 0, hit_slot = 0. Slots at or above
// RULE_SLOTS are ignored. No new item is taken until done has been shown.
// Check item (op = check): travels the cell chain, one cell per cycle, each
// cell comparing against its own rule; the first matching cell claims it.
// done pulses as the item leaves the last cell; no new item is taken until
// that done has been shown.
// Result: done marks result for exactly one cycle; the receiver cannot stall.
// Reset: clears every rule's weekday mask (no slot matches) and drops any
// item in flight; other rule fields hold their old contents until written.
module timed_ip_range_acl_match_unit #(
    parameter int RULE_SLOTS = tiracl_pkg::RULE_SLOTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  tiracl_pkg::request_t request,
    output logic                 done,
    output tiracl_pkg::result_t  result
);
    import tiracl_pkg::*;

    logic     accept;
    logic     busy_reg;
    logic     busy_next;
    logic     wr_done_reg;
    logic     wr_done_next;
    rule_wr_t wr;
    query_t   head;
    query_t   chain [RULE_SLOTS+1];
    query_t   tail;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_comb
    begin
        wr.en         = accept && (request.op == OP_WRITE);
        wr.slot       = request.slot;
        wr.low_bound  = request.range_low;
        wr.high_bound = request.range_high;
        wr.start_sec  = request.window_start;
        wr.end_sec    = request.window_end;
        wr.days       = request.day_set;
        wr.max_level  = request.level_limit;
    end

    always_comb
    begin
        head.valid         = accept && (request.op == OP_CHECK);
        head.address       = request.address;
        head.user_level    = request.user_level;
        head.second_of_day = request.second_of_day;
        head.weekday       = request.weekday;
        head.found         = 1'b0;
        head.hit           = '0;
    end

    assign chain[0] = head;

    for (genvar i = 0; i < RULE_SLOTS; i++)
    begin : g_cell
        tiracl_cell #(
            .IDX (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .wr    (wr),
            .q_in  (chain[i]),
            .q_out (chain[i+1])
        );
    end

    assign tail = chain[RULE_SLOTS];

    always_comb
    begin
        wr_done_next = wr.en;
        busy_next    = busy_reg;
        priority if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            wr_done_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            wr_done_reg <= wr_done_next;
        end
    end

    assign done            = wr_done_reg || tail.valid;
    assign result.denied   = tail.valid && tail.found;
    assign result.hit_slot = (tail.valid && tail.found) ? tail.hit : '0;

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a busy period");

    a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after item accepted");

    a_single_source: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({wr_done_reg, tail.valid}))
        else $error("write and check results collide");

    a_hit_needs_deny: assert property (@(posedge clk) disable iff (!rst_n)
        (result.hit_slot != '0 || result.denied) |-> (done && tail.valid))
        else $error("match reported without a finished check");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy held after result strobe");

endmodule

[rtl/core/tiracl_cell.sv]
module tiracl_cell #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tiracl_pkg::rule_wr_t wr,
    input  tiracl_pkg::query_t   q_in,
    output tiracl_pkg::query_t   q_out
);
    import tiracl_pkg::*;

    localparam logic [SLOT_W-1:0] SLOT_ID   = SLOT_W'(IDX);
    localparam bit                WRITABLE  = (IDX < (1 << SLOT_W));

    logic [ADDR_W-1:0]  low_reg;
    logic [ADDR_W-1:0]  high_reg;
    logic [SEC_W-1:0]   start_reg;
    logic [SEC_W-1:0]   end_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [DAYS_W-1:0]  days_reg;
    logic [DAYS_W-1:0]  days_next;
    logic               wr_hit;

    query_t q_reg;
    query_t q_next;

    logic [DAYS_W:0]    day_mask;
    logic               day_ok;
    logic               time_ok;
    logic               addr_ok;
    logic               level_ok;
    logic               rule_match;

    assign wr_hit = WRITABLE && wr.en && (wr.slot == SLOT_ID);

    always_comb
    begin
        days_next = days_reg;
        if (wr_hit)
        begin
            days_next = wr.days;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            days_reg <= '0;
        end
        else
        begin
            days_reg <= days_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            low_reg   <= wr.low_bound;
            high_reg  <= wr.high_bound;
            start_reg <= wr.start_sec;
            end_reg   <= wr.end_sec;
            level_reg <= wr.max_level;
        end
    end

    always_comb
    begin
        day_mask = (DAYS_W+1)'(1) << q_in.weekday;
        day_ok   = |({1'b0, days_reg} & day_mask);
        time_ok  = (q_in.second_of_day >= start_reg) && (q_in.second_of_day <= end_reg);
        level_ok = (q_in.user_level <= level_reg);
        addr_ok  = 1'b1;
        for (int k = 0; k < OCTETS; k++)
        begin
            if ((q_in.address[k*8 +: 8] < low_reg[k*8 +: 8]) ||
                (q_in.address[k*8 +: 8] > high_reg[k*8 +: 8]))
            begin
                addr_ok = 1'b0;
            end
        end
        rule_match = day_ok && time_ok && addr_ok && level_ok;
    end

    // first match wins: earlier cells already claimed the item
    always_comb
    begin
        q_next = q_in;
        if (!q_in.found && rule_match)
        begin
            q_next.found = 1'b1;
            q_next.hit   = SLOT_ID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q_out = q_reg;

endmodule
